// ===== rtl/pfla_pkg.sv =====
// ============================================================================
// pfla_pkg: shared types and constants for the page free list allocator
// Request and response layouts, operation codes, status codes and the
// configuration register map.
// ============================================================================
`default_nettype none

package pfla_pkg;

    // Page geometry and default sizes
    localparam int PAGE_BITS          = 12;
    localparam int FRAME_COUNT_DEF    = 65536;
    localparam int LOG_DEPTH_DEF      = 16384;

    // Field widths
    localparam int FRAME_W            = 16;
    localparam int ADDR_CFG_W         = 29;
    localparam int ENTRY_W            = 14;
    localparam int GRANT_W            = 28;

    // Reset value of the memory top register (256 MiB)
    localparam logic [ADDR_CFG_W-1:0] MEM_TOP_RESET = 29'h1000_0000;

    // Operation codes
    localparam logic [1:0] OP_FREE  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOG_EN     = 2'd0;
    localparam logic [1:0] CFG_KERNEL_END = 2'd1;
    localparam logic [1:0] CFG_MEM_TOP    = 2'd2;

    // Request carried on the input channel
    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        page_address;
        logic signed [15:0] owner_id;
        logic [ENTRY_W-1:0] entry_index;
    } t_alloc_req;

    // Response carried on the output channel
    typedef struct packed {
        logic [1:0]         status;
        logic [GRANT_W-1:0] granted_address;
        logic [FRAME_W-1:0] log_frame;
        logic signed [15:0] log_owner;
    } t_alloc_rsp;

    // One word of the link memory: successor frame and its valid flag
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_link;

endpackage

`default_nettype wire

// ===== rtl/page_free_list_allocator_core.sv =====
// ============================================================================
// page_free_list_allocator_core: LIFO page frame allocator with allocation log
// Free pages are chained through a link memory indexed by frame number. An
// allocation pops the head and advances the head by two links. Allocations
// can be recorded as (frame, owner) pairs in a log memory read back by index.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ----------------------------
//  in        to core    i_in_valid / o_in_stall  t_alloc_req (i_in)
//  out       from core  o_out_valid / i_out_stall t_alloc_rsp (o_out)
//  cfg       to core    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A free, an empty-list allocation, an unused opcode and a read past the
//  log fill go from decode straight to S_DONE; a log read passes through
//  S_LOGRD. An allocation passes through S_LINK1, and also S_LINK2 when the
//  popped head has a successor, from two dependent link memory reads. One
//  request is in work at a time; a finished response waits in the output
//  register while the next request is accepted, and a held response stalls
//  only the completion step. Reset is synchronous; the log reads as zero
//  above the fill count, so neither memory needs a clearing pass.
`default_nettype none

module page_free_list_allocator_core
    import pfla_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int LOG_DEPTH   = LOG_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_alloc_req            i_in,
    // Response channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_alloc_rsp                 o_out,
    // Configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [ADDR_CFG_W-1:0] i_cfg_data
);

    localparam int FRAME_AW = $clog2(FRAME_COUNT);
    localparam int LOG_AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W    = $clog2(LOG_DEPTH + 1);

    localparam logic [31:0]      FRAME_LIMIT = 32'(FRAME_COUNT);
    localparam logic [CNT_W-1:0] LOG_LIMIT   = CNT_W'(LOG_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK1,
        S_LINK2,
        S_LOGRD,
        S_DONE
    } t_state;

    // Control and architectural state
    t_state                  r_state, n_state;
    logic                    r_head_valid, n_head_valid;
    logic [FRAME_W-1:0]      r_head_frame, n_head_frame;
    logic [CNT_W-1:0]        r_log_count, n_log_count;
    t_alloc_rsp              r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_alloc_rsp              r_out, n_out;

    // Configuration registers
    logic                    r_log_en;
    logic [ADDR_CFG_W-1:0]   r_kernel_end;
    logic [ADDR_CFG_W-1:0]   r_mem_top;

    // Memories and their registered read data
    t_link                   link_mem [FRAME_COUNT];
    logic [31:0]             log_mem  [LOG_DEPTH];
    t_link                   r_link_rd;
    logic [31:0]             r_log_rd;

    // Memory port controls
    logic                    link_we;
    logic [FRAME_AW-1:0]     link_waddr;
    t_link                   link_wdata;
    logic                    link_re;
    logic [FRAME_AW-1:0]     link_raddr;
    logic                    log_we;
    logic [LOG_AW-1:0]       log_waddr;
    logic [31:0]             log_wdata;
    logic                    log_re;
    logic [LOG_AW-1:0]       log_raddr;

    // Widened indexes for part-selects down to the memory address widths
    logic [31:0]             head_idx;
    logic [31:0]             second_idx;
    logic [31:0]             free_frame_idx;
    logic [31:0]             free_frame_full;
    logic [31:0]             entry_idx;
    logic [31:0]             count_ext;
    logic [FRAME_W-1:0]      free_frame;
    logic                    in_acc;
    logic                    free_bad;

    assign in_acc          = i_in_valid && !o_in_stall;
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    assign free_frame      = i_in.page_address[PAGE_BITS+FRAME_W-1:PAGE_BITS];
    assign free_frame_full = 32'(i_in.page_address >> PAGE_BITS);
    assign free_frame_idx  = 32'(free_frame);
    assign head_idx        = 32'(r_head_frame);
    assign second_idx      = 32'(r_link_rd.frame);
    assign entry_idx       = 32'(i_in.entry_index);
    assign count_ext       = 32'(r_log_count);

    // A free is rejected when unaligned, outside the window or past the frames.
    assign free_bad = (i_in.page_address[PAGE_BITS-1:0] != '0)
                   || (i_in.page_address <  {3'b000, r_kernel_end})
                   || (i_in.page_address >= {3'b000, r_mem_top})
                   || (free_frame_full >= FRAME_LIMIT);

    // Sequencer: request decode, link walk, log access and completion.
    always_comb begin
        n_state      = r_state;
        n_head_valid = r_head_valid;
        n_head_frame = r_head_frame;
        n_log_count  = r_log_count;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        link_we      = 1'b0;
        link_waddr   = free_frame_idx[FRAME_AW-1:0];
        link_wdata   = '{valid: r_head_valid, frame: r_head_frame};
        link_re      = 1'b0;
        link_raddr   = head_idx[FRAME_AW-1:0];
        log_we       = 1'b0;
        log_waddr    = count_ext[LOG_AW-1:0];
        log_wdata    = {i_in.owner_id, r_head_frame};
        log_re       = 1'b0;
        log_raddr    = entry_idx[LOG_AW-1:0];

        // The waiting response leaves when the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_in.opcode)
                        OP_FREE: begin
                            if (free_bad) begin
                                n_res.status = ST_BAD;
                            end else begin
                                link_we      = 1'b1;
                                n_head_valid = 1'b1;
                                n_head_frame = free_frame;
                            end
                        end
                        OP_ALLOC: begin
                            if (!r_head_valid) begin
                                n_res.status = ST_NO_FREE;
                            end else begin
                                link_re               = 1'b1;
                                n_res.granted_address = {r_head_frame, {PAGE_BITS{1'b0}}};
                                if (r_log_en && (r_log_count < LOG_LIMIT)) begin
                                    log_we      = 1'b1;
                                    n_log_count = r_log_count + 1'b1;
                                end
                                n_state = S_LINK1;
                            end
                        end
                        OP_READ: begin
                            // Entries at or above the fill count are not read; the response stays zero.
                            if (entry_idx < count_ext) begin
                                log_re  = 1'b1;
                                n_state = S_LOGRD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LINK1: begin
                // The successor of the popped head is known; skip over it.
                if (r_link_rd.valid) begin
                    link_re    = 1'b1;
                    link_raddr = second_idx[FRAME_AW-1:0];
                    n_state    = S_LINK2;
                end else begin
                    n_head_valid = 1'b0;
                    n_head_frame = '0;
                    n_state      = S_DONE;
                end
            end
            S_LINK2: begin
                n_head_valid = r_link_rd.valid;
                n_head_frame = r_link_rd.frame;
                n_state      = S_DONE;
            end
            S_LOGRD: begin
                n_res.log_frame = r_log_rd[FRAME_W-1:0];
                n_res.log_owner = signed'(r_log_rd[31:FRAME_W]);
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, head pointer, log fill and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_valid <= 1'b0;
            r_head_frame <= '0;
            r_log_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= n_head_valid;
            r_head_frame <= n_head_frame;
            r_log_count  <= n_log_count;
            r_out_valid  <= n_out_valid;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    // Configuration registers; indexes past the map are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_en     <= 1'b0;
            r_kernel_end <= '0;
            r_mem_top    <= MEM_TOP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOG_EN:     r_log_en     <= i_cfg_data[0];
                CFG_KERNEL_END: r_kernel_end <= i_cfg_data;
                CFG_MEM_TOP:    r_mem_top    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Link memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_rd <= link_mem[link_raddr];
        end
    end

    // Log memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (log_we) begin
            log_mem[log_waddr] <= log_wdata;
        end
        if (log_re) begin
            r_log_rd <= log_mem[log_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== bench/page_free_list_allocator_core_test.sv =====
// ============================================================================
// page_free_list_allocator_core_test: self-checking bench for the allocator
// Drives free, allocate, log read and unused requests through the request
// channel. Each response is checked field by field against a literal
// expectation or a behavioral copy of the free list and allocation log.
// A directed table comes first, then random phases under several register
// settings with random idling on both channels, then a short idle-free
// pass of back-to-back free and allocate pairs followed by mixed requests.
// ============================================================================
`timescale 1ns / 1ps

module page_free_list_allocator_core_test;
    import pfla_pkg::*;

    // The opcode that no operation uses
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT = 1000;
    // Cycles allowed for the core to come to rest before a register write
    localparam int REST_CYCLES = 8;
    localparam int DIR_N       = 25;
    localparam int PHASE_N     = 5;

    typedef struct {
        t_alloc_req req;
        bit         fixed;
        t_alloc_rsp rsp;
    } t_dir_row;

    typedef struct {
        bit                    log_on;
        logic [ADDR_CFG_W-1:0] kend;
        logic [ADDR_CFG_W-1:0] top;
        int                    base;
        int                    count;
    } t_phase;

    logic                  i_clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  out_stall;
    logic                  cfg_valid;
    logic [1:0]            cfg_index;
    logic [ADDR_CFG_W-1:0] cfg_data;
    t_alloc_req            in_data;
    wire                   o_in_stall;
    wire                   o_out_valid;
    wire                   o_cfg_ready;
    t_alloc_rsp            o_out;

    // Literal expectation that travels with a directed request
    bit                    drv_fixed;
    t_alloc_rsp            drv_fixed_rsp;
    bit                    idle_on;
    int                    stall_left;

    // Behavioral copy of the allocator state
    bit                    log_on = 1'b0;
    logic [ADDR_CFG_W-1:0] kend   = '0;
    logic [ADDR_CFG_W-1:0] top    = MEM_TOP_RESET;
    t_link                 head;
    t_link                 links [FRAME_COUNT_DEF];
    logic [31:0]           log_mem [LOG_DEPTH_DEF];
    int                    log_fill;

    t_alloc_rsp            rsp_owed [$];
    int                    errors;
    int                    n_req, n_grant, n_empty, n_bad, n_read, n_cfg;

    t_dir_row              dir_rows [DIR_N];
    t_phase                phases [PHASE_N];

    page_free_list_allocator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Print one mismatch line and count it.
    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Work out the response to one request and advance the state copy.
    task automatic allocator_response(input t_alloc_req r, output t_alloc_rsp p);
        logic [15:0] f;
        t_link       s;
        bit          bad;
        p = '0;
        n_req++;
        case (r.opcode)
            OP_FREE: begin
                bad = (r.page_address[PAGE_BITS-1:0] != '0) ||
                      (r.page_address < {3'b000, kend}) ||
                      (r.page_address >= {3'b000, top}) ||
                      (r.page_address[31:28] != 4'h0);
                if (bad) begin
                    p.status = ST_BAD;
                    n_bad++;
                end else begin
                    f = r.page_address[27:12];
                    links[f] = head;
                    head = '{valid: 1'b1, frame: f};
                end
            end
            OP_ALLOC: begin
                if (!head.valid) begin
                    p.status = ST_NO_FREE;
                    n_empty++;
                end else begin
                    // Pop the head and step over its successor.
                    f = head.frame;
                    s = links[f];
                    head = s.valid ? links[s.frame] : '0;
                    if (log_on && log_fill < LOG_DEPTH_DEF) begin
                        log_mem[log_fill] = {r.owner_id, f};
                        log_fill++;
                    end
                    p.granted_address = {f, 12'h000};
                    n_grant++;
                end
            end
            OP_READ: begin
                n_read++;
                if (r.entry_index < LOG_DEPTH_DEF) begin
                    p.log_frame = log_mem[r.entry_index][15:0];
                    p.log_owner = log_mem[r.entry_index][31:16];
                end
            end
            default: ;
        endcase
    endtask

    // Sample every handshake at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_alloc_rsp pred;
        t_alloc_rsp want;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                allocator_response(in_data, pred);
                rsp_owed.push_back(drv_fixed ? drv_fixed_rsp : pred);
            end
            if (o_out_valid && !out_stall) begin
                if (rsp_owed.size() == 0) begin
                    flag_error("response with no request outstanding");
                end else begin
                    want = rsp_owed.pop_front();
                    if (o_out.status !== want.status)
                        flag_error($sformatf("status %0d, expected %0d",
                                             o_out.status, want.status));
                    if (o_out.granted_address !== want.granted_address)
                        flag_error($sformatf("granted_address %h, expected %h",
                                             o_out.granted_address, want.granted_address));
                    if (o_out.log_frame !== want.log_frame)
                        flag_error($sformatf("log_frame %h, expected %h",
                                             o_out.log_frame, want.log_frame));
                    if (o_out.log_owner !== want.log_owner)
                        flag_error($sformatf("log_owner %0d, expected %0d",
                                             o_out.log_owner, want.log_owner));
                end
            end
            if (cfg_valid && o_cfg_ready) begin
                n_cfg++;
                case (cfg_index)
                    CFG_LOG_EN:     log_on = cfg_data[0];
                    CFG_KERNEL_END: kend = cfg_data;
                    CFG_MEM_TOP:    top = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Response side stalls in random bursts while idling is on.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Hang detection: no handshake of any kind for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("page_free_list_allocator_core_test: done, errors");
        $finish;
    end

    // Offer one request from a falling edge and return at the falling edge
    // after it is taken, with valid still high.
    task automatic send_request(input t_alloc_req r, input bit fixed, input t_alloc_rsp lit);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_valid      <= 1'b1;
        in_data       <= r;
        drv_fixed     <= fixed;
        drv_fixed_rsp <= lit;
        do @(posedge i_clk); while (!(in_valid && !o_in_stall));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every response is in and the core is at rest.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rsp_owed.size() != 0) @(posedge i_clk);
        repeat (REST_CYCLES) @(negedge i_clk);
    endtask

    // One register write on the configuration channel.
    task automatic write_reg(input logic [1:0] idx, input logic [ADDR_CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input bit lg, input logic [ADDR_CFG_W-1:0] ke,
                              input logic [ADDR_CFG_W-1:0] tp);
        wait_drained();
        write_reg(CFG_LOG_EN, {28'h0, lg});
        write_reg(CFG_KERNEL_END, ke);
        write_reg(CFG_MEM_TOP, tp);
    endtask

    function automatic t_dir_row mk_row(input logic [1:0] op, input logic [31:0] addr,
                                        input logic signed [15:0] own,
                                        input logic [ENTRY_W-1:0] idx, input bit fixed,
                                        input logic [1:0] st, input logic [GRANT_W-1:0] gr,
                                        input logic [15:0] lf,
                                        input logic signed [15:0] lo);
        t_dir_row d;
        d.req   = '{opcode: op, page_address: addr, owner_id: own, entry_index: idx};
        d.fixed = fixed;
        d.rsp   = '{status: st, granted_address: gr, log_frame: lf, log_owner: lo};
        return d;
    endfunction

    // Random request with all fields scrambled; frees mostly hit a small
    // pool of frames so that the list grows deep and links are reused.
    function automatic t_alloc_req rand_request(input int base);
        t_alloc_req  r;
        int          sel;
        logic [15:0] pf;
        r   = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        pf  = 16'(base + $urandom_range(0, 63));
        if (sel < 50) begin
            r.opcode = OP_FREE;
            case ($urandom_range(0, 9))
                7:       r.page_address = {4'h0, 16'($urandom), 12'h000};
                8:       r.page_address = {4'h0, pf, 12'($urandom_range(1, 4095))};
                9:       ;
                default: r.page_address = {4'h0, pf, 12'h000};
            endcase
        end else if (sel < 80) begin
            r.opcode = OP_ALLOC;
        end else if (sel < 95) begin
            r.opcode = OP_READ;
            if ($urandom_range(0, 3) != 0)
                r.entry_index = 14'($urandom_range(0, (log_fill > 16380) ? 16383
                                                                           : log_fill + 3));
        end else begin
            r.opcode = OP_UNUSED;
        end
        return r;
    endfunction

    initial begin : stimulus
        t_alloc_req r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LOG_EN;
        cfg_data  = '0;
        drv_fixed = 1'b0;
        drv_fixed_rsp = '0;
        idle_on   = 1'b0;
        stall_left = 0;
        errors    = 0;
        log_fill  = 0;
        head      = '0;
        {n_req, n_grant, n_empty, n_bad, n_read, n_cfg} = '0;
        foreach (links[i]) links[i] = '0;
        foreach (log_mem[i]) log_mem[i] = '0;

        // Directed table. Rows with a typed expectation are fixed.
        dir_rows[0]  = mk_row(OP_ALLOC, 32'h0, 16'sh0, 14'h0, 1, ST_NO_FREE, 0, 0, 0);
        dir_rows[1]  = mk_row(OP_READ, 32'h0, 16'sh0, 14'h0, 1, ST_OK, 0, 0, 0);
        dir_rows[2]  = mk_row(OP_READ, 32'hffff_ffff, -16'sd1, 14'h3fff, 1, ST_OK, 0, 0, 0);
        dir_rows[3]  = mk_row(OP_UNUSED, 32'hffff_ffff, -16'sd1, 14'h3fff, 1, ST_OK, 0, 0, 0);
        // Bad frees: unaligned, below kernel end, at the top, frame out of range.
        dir_rows[4]  = mk_row(OP_FREE, 32'h0020_0001, 16'sh0, 14'h0, 1, ST_BAD, 0, 0, 0);
        dir_rows[5]  = mk_row(OP_FREE, 32'h000f_f000, 16'sh0, 14'h0, 1, ST_BAD, 0, 0, 0);
        dir_rows[6]  = mk_row(OP_FREE, 32'h1000_0000, 16'sh0, 14'h0, 1, ST_BAD, 0, 0, 0);
        dir_rows[7]  = mk_row(OP_FREE, 32'hffff_f000, 16'sh0, 14'h0, 1, ST_BAD, 0, 0, 0);
        // Last frame in, then out for the kernel; it has no successor.
        dir_rows[8]  = mk_row(OP_FREE, 32'h0fff_f000, 16'sh0, 14'h0, 1, ST_OK, 0, 0, 0);
        dir_rows[9]  = mk_row(OP_ALLOC, 32'h0, -16'sd2, 14'h0, 1, ST_OK, 28'hffff000, 0, 0);
        dir_rows[10] = mk_row(OP_ALLOC, 32'h0, 16'sh0, 14'h0, 1, ST_NO_FREE, 0, 0, 0);
        dir_rows[11] = mk_row(OP_READ, 32'h0, 16'sh0, 14'h0, 1, ST_OK, 0, 16'hffff, -16'sd2);
        dir_rows[12] = mk_row(OP_FREE, 32'h0010_0000, 16'sh0, 14'h0, 1, ST_OK, 0, 0, 0);
        dir_rows[13] = mk_row(OP_FREE, 32'h0020_0000, 16'sh0, 14'h0, 1, ST_OK, 0, 0, 0);
        dir_rows[14] = mk_row(OP_FREE, 32'h0030_0000, 16'sh0, 14'h0, 1, ST_OK, 0, 0, 0);
        // Pops that skip a page, owner extremes.
        dir_rows[15] = mk_row(OP_ALLOC, 32'h0, 16'sh7fff, 14'h0, 0, 0, 0, 0, 0);
        dir_rows[16] = mk_row(OP_ALLOC, 32'h0, -16'sd32768, 14'h0, 0, 0, 0, 0, 0);
        dir_rows[17] = mk_row(OP_ALLOC, 32'h0, 16'sh5, 14'h0, 0, 0, 0, 0, 0);
        // Double free leaves a cycle in the list.
        dir_rows[18] = mk_row(OP_FREE, 32'h0040_0000, 16'sh0, 14'h0, 0, 0, 0, 0, 0);
        dir_rows[19] = mk_row(OP_FREE, 32'h0040_0000, 16'sh0, 14'h0, 0, 0, 0, 0, 0);
        dir_rows[20] = mk_row(OP_ALLOC, 32'h0, 16'sh1, 14'h0, 0, 0, 0, 0, 0);
        dir_rows[21] = mk_row(OP_ALLOC, 32'h0, 16'sh2, 14'h0, 0, 0, 0, 0, 0);
        dir_rows[22] = mk_row(OP_READ, 32'h0, 16'sh0, 14'h1, 0, 0, 0, 0, 0);
        dir_rows[23] = mk_row(OP_READ, 32'h0, 16'sh0, 14'h2, 0, 0, 0, 0, 0);
        dir_rows[24] = mk_row(OP_READ, 32'h0, 16'sh0, 14'h4, 0, 0, 0, 0, 0);

        // Random phases: logging, kernel end, memory top, pool base, length.
        phases[0] = '{1'b1, 29'h0000_0000, 29'h1000_0000, 'h0000, 350};
        phases[1] = '{1'b0, 29'h1fff_ffff, 29'h1fff_ffff, 'hff00, 200};
        phases[2] = '{1'b1, 29'h0040_0000, 29'h0080_0000, 'h03f0, 300};
        phases[3] = '{1'b1, 29'h0000_0000, 29'h0000_0000, 'h0010, 150};
        phases[4] = '{1'b1, 29'h0000_1000, 29'h0fff_f000, 'hffc0, 350};

        repeat (4) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        set_config(1'b1, 29'h0010_0000, MEM_TOP_RESET);
        idle_on = 1'b1;
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

        // Random part under each register setting.
        foreach (phases[k]) begin
            set_config(phases[k].log_on, phases[k].kend, phases[k].top);
            repeat (phases[k].count) send_request(rand_request(phases[k].base), 0, '0);
        end

        // Idle-free pass: back-to-back free and allocate pairs, then mixed requests.
        idle_on = 1'b0;
        set_config(1'b1, 29'h0, MEM_TOP_RESET);
        repeat (10) begin
            r = {$urandom, $urandom};
            r.opcode = OP_FREE;
            r.page_address = {4'h0, 16'(16'h0100 + $urandom_range(0, 255)), 12'h000};
            send_request(r, 0, '0);
            r = {$urandom, $urandom};
            r.opcode = OP_ALLOC;
            send_request(r, 0, '0);
        end
        repeat (60) begin
            r = rand_request('h0200);
            if (r.opcode == OP_UNUSED) r.entry_index = 14'h3fff;
            send_request(r, 0, '0);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (rsp_owed.size() != 0)
            flag_error($sformatf("%0d responses never arrived", rsp_owed.size()));

        $display("run covered %0d requests: %0d grants, %0d empty-list allocs, %0d bad frees,",
                 n_req, n_grant, n_empty, n_bad);
        $display("%0d log reads, %0d register writes, %0d log records held at the end",
                 n_read, n_cfg, log_fill);
        if (errors == 0)
            $display("page_free_list_allocator_core_test: done, clean");
        else
            $display("page_free_list_allocator_core_test: done, errors");
        $finish;
    end

endmodule
